FILE: rtl/cau_pkg.sv
`default_nettype none
package cau_pkg;

  localparam int W  = 16;
  localparam int F  = 12;
  localparam int PW = 2 * W;
  localparam int SW = 2 * W + 1;
  localparam int MW = 2 * W;
  localparam int QW = W + 1;
  localparam int NW = MW + F;
  localparam int DW = MW + QW;
  localparam int CW = (NW > DW) ? NW : DW;

  localparam logic [2:0] CMD_ADD = 3'd0;
  localparam logic [2:0] CMD_SUB = 3'd1;
  localparam logic [2:0] CMD_MUL = 3'd2;
  localparam logic [2:0] CMD_DIV = 3'd3;
  localparam logic [2:0] CMD_EQ  = 3'd4;
  localparam logic [2:0] CMD_CNJ = 3'd5;

  localparam logic signed [SW-1:0] SAT_HI = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [SW-1:0] SAT_LO = {{(SW-W+1){1'b1}}, {(W-1){1'b0}}};
  localparam logic [QW-1:0] Q_MAXP = {2'b00, {(W-1){1'b1}}};
  localparam logic [QW-1:0] Q_MAXN = {2'b01, {(W-1){1'b0}}};

  typedef struct packed {
    logic [2:0]          cmd;
    logic signed [W-1:0] a_re;
    logic signed [W-1:0] a_im;
    logic signed [W-1:0] b_re;
    logic signed [W-1:0] b_im;
  } op_t;

  typedef struct packed {
    logic signed [W-1:0] res_re;
    logic signed [W-1:0] res_im;
    logic                is_equal;
    logic                div_by_zero;
    logic                overflow;
  } res_t;

  typedef struct packed {
    logic signed [W-1:0] val;
    logic                ov;
  } sat_t;

  typedef struct packed {
    logic [2:0]           cmd;
    res_t                 early;
    logic signed [PW-1:0] p_rr;
    logic signed [PW-1:0] p_ii;
    logic signed [PW-1:0] p_ri;
    logic signed [PW-1:0] p_ir;
    logic signed [PW-1:0] p_bb_re;
    logic signed [PW-1:0] p_bb_im;
  } pa_t;

  typedef struct packed {
    logic [2:0]    cmd;
    res_t          early;
    logic [1:0]    neg;
    logic [MW-1:0] mag_re;
    logic [MW-1:0] mag_im;
    logic [MW-1:0] den;
  } pb_t;

  typedef struct packed {
    logic [2:0]    cmd;
    res_t          early;
    logic [1:0]    neg;
    logic [1:0]    big;
    logic [MW-1:0] rem_re;
    logic [MW-1:0] rem_im;
    logic [QW-1:0] low_re;
    logic [QW-1:0] low_im;
    logic [QW-1:0] q_re;
    logic [QW-1:0] q_im;
    logic [MW-1:0] den;
  } dv_t;

  function automatic sat_t sat_w(input logic signed [SW-1:0] v);
    sat_t r;
    r.ov  = 1'b0;
    r.val = v[W-1:0];
    if (v > SAT_HI) begin
      r.ov  = 1'b1;
      r.val = SAT_HI[W-1:0];
    end else if (v < SAT_LO) begin
      r.ov  = 1'b1;
      r.val = SAT_LO[W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/cau_prod.sv
`default_nettype none
module cau_prod (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          op_valid,
  output logic               op_stall,
  input  wire cau_pkg::op_t  op,
  output logic               pa_valid,
  input  wire logic          pa_stall,
  output cau_pkg::pa_t       pa
);
  import cau_pkg::*;

  logic en;
  pa_t  pa_next;
  sat_t s_re, s_im;

  assign en       = !pa_valid || !pa_stall;
  assign op_stall = !en;

  always_comb begin
    pa_next         = '0;
    pa_next.cmd     = op.cmd;
    pa_next.p_rr    = PW'(op.a_re * op.b_re);
    pa_next.p_ii    = PW'(op.a_im * op.b_im);
    pa_next.p_ri    = PW'(op.a_re * op.b_im);
    pa_next.p_ir    = PW'(op.a_im * op.b_re);
    pa_next.p_bb_re = PW'(op.b_re * op.b_re);
    pa_next.p_bb_im = PW'(op.b_im * op.b_im);
    s_re = '0;
    s_im = '0;
    case (op.cmd)
      CMD_ADD: begin
        s_re = sat_w(SW'(op.a_re) + SW'(op.b_re));
        s_im = sat_w(SW'(op.a_im) + SW'(op.b_im));
      end
      CMD_SUB: begin
        s_re = sat_w(SW'(op.a_re) - SW'(op.b_re));
        s_im = sat_w(SW'(op.a_im) - SW'(op.b_im));
      end
      CMD_CNJ: begin
        s_re = sat_w(SW'(op.a_re));
        s_im = sat_w(-SW'(op.a_im));
      end
      default: begin
        s_re = '0;
        s_im = '0;
      end
    endcase
    pa_next.early.res_re   = s_re.val;
    pa_next.early.res_im   = s_im.val;
    pa_next.early.overflow = s_re.ov || s_im.ov;
    pa_next.early.is_equal = (op.cmd == CMD_EQ) && (op.a_re == op.b_re)
                             && (op.a_im == op.b_im);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pa_valid <= 1'b0;
    end else if (en) begin
      pa_valid <= op_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && op_valid) begin
      pa <= pa_next;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/cau_comb.sv
`default_nettype none
module cau_comb (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          pa_valid,
  output logic               pa_stall,
  input  wire cau_pkg::pa_t  pa,
  output logic               pb_valid,
  input  wire logic          pb_stall,
  output cau_pkg::pb_t       pb
);
  import cau_pkg::*;

  logic                 en;
  pb_t                  pb_next;
  logic signed [SW-1:0] m_re, m_im, n_re, n_im;
  sat_t                 s_re, s_im;

  assign en       = !pb_valid || !pb_stall;
  assign pa_stall = !en;

  always_comb begin
    m_re = (SW'(pa.p_rr) - SW'(pa.p_ii)) >>> F;
    m_im = (SW'(pa.p_ri) + SW'(pa.p_ir)) >>> F;
    n_re = SW'(pa.p_rr) + SW'(pa.p_ii);
    n_im = SW'(pa.p_ir) - SW'(pa.p_ri);
    s_re = sat_w(m_re);
    s_im = sat_w(m_im);
    pb_next        = '0;
    pb_next.cmd    = pa.cmd;
    pb_next.early  = pa.early;
    if (pa.cmd == CMD_MUL) begin
      pb_next.early.res_re   = s_re.val;
      pb_next.early.res_im   = s_im.val;
      pb_next.early.overflow = s_re.ov || s_im.ov;
    end
    pb_next.neg    = {n_im[SW-1], n_re[SW-1]};
    pb_next.mag_re = n_re[SW-1] ? MW'(-n_re) : MW'(n_re);
    pb_next.mag_im = n_im[SW-1] ? MW'(-n_im) : MW'(n_im);
    pb_next.den    = MW'($unsigned(pa.p_bb_re)) + MW'($unsigned(pa.p_bb_im));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pb_valid <= 1'b0;
    end else if (en) begin
      pb_valid <= pa_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && pa_valid) begin
      pb <= pb_next;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/cau_div.sv
`default_nettype none
module cau_div (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          pb_valid,
  output logic               pb_stall,
  input  wire cau_pkg::pb_t  pb,
  output logic               res_valid,
  input  wire logic          res_stall,
  output cau_pkg::res_t      res
);
  import cau_pkg::*;

  dv_t        st [QW+1];
  logic       v  [QW+1];
  logic       en [QW+2];
  dv_t        d0;
  logic [CW-1:0] num_re, num_im, den_sh;
  res_t       res_next;
  sat_t       f_re, f_im;
  dv_t        last;

  assign en[QW+1] = !res_valid || !res_stall;
  assign pb_stall = !en[0];

  genvar g;
  generate
    for (g = 0; g <= QW; g++) begin : g_en
      assign en[g] = !v[g] || en[g+1];
    end
  endgenerate

  // setup: overflow check and first partial remainder
  always_comb begin
    num_re    = CW'(pb.mag_re) << F;
    num_im    = CW'(pb.mag_im) << F;
    den_sh    = CW'(pb.den) << QW;
    d0        = '0;
    d0.cmd    = pb.cmd;
    d0.early  = pb.early;
    d0.neg    = pb.neg;
    d0.den    = pb.den;
    d0.big    = {num_im >= den_sh, num_re >= den_sh};
    d0.rem_re = MW'(num_re >> QW);
    d0.rem_im = MW'(num_im >> QW);
    d0.low_re = num_re[QW-1:0];
    d0.low_im = num_im[QW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en[0]) begin
      v[0] <= pb_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0] && pb_valid) begin
      st[0] <= d0;
    end
  end

  // one quotient bit per stage for each lane
  generate
    for (g = 1; g <= QW; g++) begin : g_step
      dv_t           nx;
      logic [MW:0]   r2_re, r2_im;
      logic          qb_re, qb_im;

      always_comb begin
        nx     = st[g-1];
        r2_re  = {st[g-1].rem_re, st[g-1].low_re[QW-1]};
        r2_im  = {st[g-1].rem_im, st[g-1].low_im[QW-1]};
        qb_re  = r2_re >= {1'b0, st[g-1].den};
        qb_im  = r2_im >= {1'b0, st[g-1].den};
        nx.rem_re = qb_re ? MW'(r2_re - {1'b0, st[g-1].den}) : r2_re[MW-1:0];
        nx.rem_im = qb_im ? MW'(r2_im - {1'b0, st[g-1].den}) : r2_im[MW-1:0];
        nx.low_re = st[g-1].low_re << 1;
        nx.low_im = st[g-1].low_im << 1;
        nx.q_re   = {st[g-1].q_re[QW-2:0], qb_re};
        nx.q_im   = {st[g-1].q_im[QW-2:0], qb_im};
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          v[g] <= 1'b0;
        end else if (en[g]) begin
          v[g] <= v[g-1];
        end
      end

      always_ff @(posedge clk) begin
        if (en[g] && v[g-1]) begin
          st[g] <= nx;
        end
      end
    end
  endgenerate

  function automatic sat_t div_fin(input logic neg, input logic big,
                                   input logic [QW-1:0] q);
    sat_t r;
    logic [QW:0] nq;
    nq    = -{1'b0, q};
    r.ov  = 1'b0;
    r.val = q[W-1:0];
    if (!neg) begin
      if (big || q > Q_MAXP) begin
        r.ov  = 1'b1;
        r.val = SAT_HI[W-1:0];
      end
    end else begin
      r.val = nq[W-1:0];
      if (big || q > Q_MAXN) begin
        r.ov  = 1'b1;
        r.val = SAT_LO[W-1:0];
      end
    end
    return r;
  endfunction

  always_comb begin
    last     = st[QW];
    f_re     = div_fin(last.neg[0], last.big[0], last.q_re);
    f_im     = div_fin(last.neg[1], last.big[1], last.q_im);
    res_next = last.early;
    if (last.cmd == CMD_DIV) begin
      res_next.is_equal = 1'b0;
      if (last.den == '0) begin
        res_next.res_re      = '0;
        res_next.res_im      = '0;
        res_next.overflow    = 1'b0;
        res_next.div_by_zero = 1'b1;
      end else begin
        res_next.res_re      = f_re.val;
        res_next.res_im      = f_im.val;
        res_next.overflow    = f_re.ov || f_im.ov;
        res_next.div_by_zero = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en[QW+1]) begin
      res_valid <= v[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en[QW+1] && v[QW]) begin
      res <= res_next;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/complex_arithmetic_unit.sv
// channel  | valid     | stall     | payload
// request  | op_valid  | op_stall  | op  (cmd, a_re, a_im, b_re, b_im)
// result   | res_valid | res_stall | res (res_re, res_im, is_equal, div_by_zero, overflow)
//
// one request per cycle while op_stall is low; the divider is a restoring
// divider, one quotient bit per stage
// every stage has its own valid bit; a stall fills bubbles before it backs up
// synchronous active-high reset clears the valid bits only
`default_nettype none
module complex_arithmetic_unit (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          op_valid,
  output logic               op_stall,
  input  wire cau_pkg::op_t  op,
  output logic               res_valid,
  input  wire logic          res_stall,
  output cau_pkg::res_t      res
);
  import cau_pkg::*;

  logic pa_valid, pa_stall, pb_valid, pb_stall;
  pa_t  pa;
  pb_t  pb;

  cau_prod u_prod (
    .clk, .rst, .op_valid, .op_stall, .op,
    .pa_valid, .pa_stall, .pa
  );

  cau_comb u_comb (
    .clk, .rst, .pa_valid, .pa_stall, .pa,
    .pb_valid, .pb_stall, .pb
  );

  cau_div u_div (
    .clk, .rst, .pb_valid, .pb_stall, .pb,
    .res_valid, .res_stall, .res
  );

`ifndef ASSERT_OFF
  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.div_by_zero |-> res.res_re == '0 && res.res_im == '0 && !res.overflow)
    else $error("divide by zero result not cleared");

  a_flag_excl: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res.is_equal && (res.div_by_zero || res.overflow)))
    else $error("compare flag mixed with other flags");

  a_eq_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.is_equal |-> res.res_re == '0 && res.res_im == '0)
    else $error("compare result parts not zero");

  a_no_stall: assert property (@(posedge clk) disable iff (rst)
    !res_valid && !pb_valid && !pa_valid |-> !op_stall)
    else $error("request stalled with empty pipeline ends");
`endif

endmodule
`default_nettype wire
